@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define XTEA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xtea assertion failed");

// next-cycle implication, disabled while reset is low
`define XTEA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xtea assertion failed");

`endif

@@ src/xtea_pkg.sv @@
// ----------------------------------------------------------------------------
// xtea_pkg
// types and constants shared by the xtea block cipher modules
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam int WORD_W    = 32;
    localparam int ROUNDS_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int KEY_WORDS = 4;

    localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

    localparam logic [WORD_W-1:0]   KEY0_RESET   = 32'h0000_FDA5;
    localparam logic [WORD_W-1:0]   KEY1_RESET   = 32'h0000_D54E;
    localparam logic [WORD_W-1:0]   KEY2_RESET   = 32'h0000_FC00;
    localparam logic [WORD_W-1:0]   KEY3_RESET   = 32'h0000_B55A;
    localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 8'd32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS = 3'd4;

    // direction codes
    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } t_xtea_req;

    typedef struct packed {
        logic [WORD_W-1:0] first_result;
        logic [WORD_W-1:0] second_result;
    } t_xtea_rsp;

    typedef struct packed {
        logic load;
        logic step;
        logic phase;
    } t_xtea_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_xtea_state;

endpackage

@@ src/xtea_dp.sv @@
// ----------------------------------------------------------------------------
// xtea_dp
// datapath: block halves and running sum, one half-round per step command
// ----------------------------------------------------------------------------
module xtea_dp
    import xtea_pkg::*;
(
    input  logic                i_clk,
    input  t_xtea_cmd           i_cmd,
    input  t_xtea_req           i_req,
    input  t_key                i_key,
    input  logic [ROUNDS_W-1:0] i_round_cnt,
    output t_xtea_rsp           o_rsp
);

    logic [WORD_W-1:0] r_v0, n_v0;
    logic [WORD_W-1:0] r_v1, n_v1;
    logic [WORD_W-1:0] r_sum, n_sum;
    logic              r_op, n_op;

    logic                  upd_v1;
    logic [WORD_W-1:0]     src;
    logic [WORD_W-1:0]     dst;
    logic [1:0]            kidx;
    logic [WORD_W-1:0]     f_val;
    logic [WORD_W-1:0]     res;
    logic [WORD_W-1:0]     dec_prod;

    function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    always_comb begin
        upd_v1   = r_op ^ i_cmd.phase;
        src      = upd_v1 ? r_v0 : r_v1;
        dst      = upd_v1 ? r_v1 : r_v0;
        kidx     = upd_v1 ? r_sum[12:11] : r_sum[1:0];
        f_val    = mix(src) ^ (r_sum + i_key[kidx]);
        res      = (r_op == OP_DEC) ? (dst - f_val) : (dst + f_val);
        dec_prod = XTEA_DELTA * WORD_W'(i_round_cnt);

        n_v0  = r_v0;
        n_v1  = r_v1;
        n_sum = r_sum;
        n_op  = r_op;
        if (i_cmd.load) begin
            n_op  = i_req.op;
            n_v0  = i_req.first_word;
            n_v1  = i_req.second_word;
            n_sum = (i_req.op == OP_DEC) ? dec_prod : '0;
        end else if (i_cmd.step) begin
            if (upd_v1) begin
                n_v1 = res;
            end else begin
                n_v0 = res;
            end
            if (!i_cmd.phase) begin
                n_sum = (r_op == OP_DEC) ? (r_sum - XTEA_DELTA) : (r_sum + XTEA_DELTA);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v0  <= n_v0;
        r_v1  <= n_v1;
        r_sum <= n_sum;
        r_op  <= n_op;
    end

    assign o_rsp.first_result  = r_v0;
    assign o_rsp.second_result = r_v1;

endmodule

@@ src/xtea_ctrl.sv @@
// ----------------------------------------------------------------------------
// xtea_ctrl
// controller: sequences load, two half-rounds per round, and the done strobe
// ----------------------------------------------------------------------------
module xtea_ctrl
    import xtea_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [ROUNDS_W-1:0] i_round_cnt,
    output t_xtea_cmd           o_cmd,
    output logic                o_busy,
    output logic                o_done
);

    t_xtea_state         r_state, n_state;
    logic [ROUNDS_W-1:0] r_rounds, n_rounds;
    logic                r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rounds <= '0;
            r_phase  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rounds <= n_rounds;
            r_phase  <= n_phase;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_rounds = r_rounds;
        n_phase  = r_phase;
        o_cmd    = '0;
        o_busy   = 1'b1;
        o_done   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_rounds   = i_round_cnt;
                    n_phase    = 1'b0;
                    n_state    = (i_round_cnt == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.step  = 1'b1;
                o_cmd.phase = r_phase;
                n_phase     = ~r_phase;
                if (r_phase) begin
                    n_rounds = r_rounds - ROUNDS_W'(1);
                    if (r_rounds == ROUNDS_W'(1)) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/xtea_block_cipher_top.sv @@
// ----------------------------------------------------------------------------
// xtea_block_cipher_top
// xtea block cipher, 64-bit block, 128-bit key, configurable round count
// ----------------------------------------------------------------------------
// usage:
//   request channel: drive i_req (op, first_word, second_word) with i_start;
//   the request is taken on a clock edge where i_start is high and o_busy low.
//   result channel: o_rsp is valid for exactly one cycle while o_done is high;
//   the receiver cannot stall, so it must capture the result in that cycle.
//   config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
//   index 0..3 are the key words, 4 the round count, other indexes ignored.
//   o_cfg_ready is high while the block is idle and no request is offered.
// timing:
//   the request is loaded at the accepting edge, then each half-round runs in
//   the shared round unit, followed by the done strobe; at zero rounds the
//   done strobe follows the load directly.
//   the next request is accepted in the cycle after o_done, so a new request
//   is taken only once the previous result has been strobed.
// reset:
//   synchronous, active low; the controller returns to idle and the key and
//   round count registers take their default values.
// ----------------------------------------------------------------------------
module xtea_block_cipher_top
    import xtea_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_xtea_req            i_req,
    output logic                 o_busy,
    output logic                 o_done,
    output t_xtea_rsp            o_rsp,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_key                r_key;
    logic [ROUNDS_W-1:0] r_round_cnt;
    t_xtea_cmd           cmd;
    logic                cfg_we;

    assign o_cfg_ready = ~o_busy & ~i_start;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0]    <= KEY0_RESET;
            r_key[1]    <= KEY1_RESET;
            r_key[2]    <= KEY2_RESET;
            r_key[3]    <= KEY3_RESET;
            r_round_cnt <= ROUNDS_RESET;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY0:   r_key[0]    <= i_cfg_data;
                CFG_KEY1:   r_key[1]    <= i_cfg_data;
                CFG_KEY2:   r_key[2]    <= i_cfg_data;
                CFG_KEY3:   r_key[3]    <= i_cfg_data;
                CFG_ROUNDS: r_round_cnt <= i_cfg_data[ROUNDS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    xtea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_round_cnt (r_round_cnt),
        .o_cmd       (cmd),
        .o_busy      (o_busy),
        .o_done      (o_done)
    );

    xtea_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_key       (r_key),
        .i_round_cnt (r_round_cnt),
        .o_rsp       (o_rsp)
    );

endmodule

@@ src/xtea_checker.sv @@
// ----------------------------------------------------------------------------
// xtea_checker
// port-level checks on the request/result sequencing of the cipher top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xtea_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_done
);

    // accepted request makes the block busy
    `XTEA_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // a result only shows while a request is in flight
    `XTEA_ASSERT_IMP(a_done_busy, i_clk, i_rst_n, o_done, o_busy)
    // result strobe is a single cycle and frees the block
    `XTEA_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_done, !o_busy && !o_done)
    // busy only drops through a result strobe
    `XTEA_ASSERT_NXT(a_busy_end, i_clk, i_rst_n, o_busy && !o_done, o_busy)

endmodule

bind xtea_block_cipher_top xtea_checker u_xtea_checker (.*);

@@ tb/tb_xtea_block_cipher_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xtea_block_cipher_top
// self-checking testbench for the xtea block cipher
// ----------------------------------------------------------------------------
// Sends 64-bit blocks in both directions under several key and round count
// settings. Covered settings are the reset defaults, zero, one and 255
// rounds, all-zero and all-one keys, and writes to unused register indexes.
// A behavioral cipher in the testbench predicts every block. Each strobed
// result is compared field by field with the oldest prediction.
// Random gaps are inserted on the request side between blocks.
// ----------------------------------------------------------------------------
module tb_xtea_block_cipher_top;
    import xtea_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_PHASES = 16;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_start     = 1'b0;
    t_xtea_req            i_req       = '0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data  = '0;
    logic                 o_busy;
    logic                 o_done;
    t_xtea_rsp            o_rsp;
    logic                 o_cfg_ready;

    t_key                key_shadow    = {KEY3_RESET, KEY2_RESET, KEY1_RESET, KEY0_RESET};
    logic [ROUNDS_W-1:0] rounds_shadow = ROUNDS_RESET;
    t_xtea_rsp           pending_blocks[$];
    int unsigned         mismatch_count = 0;
    int unsigned         progress_ticks = 0;
    int unsigned         seen_ticks     = 0;
    int unsigned         stall_cycles   = 0;

    xtea_block_cipher_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [WORD_W-1:0] feistel_mix(input logic [WORD_W-1:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    function automatic t_xtea_rsp xtea_transform(input t_xtea_req req);
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] sum;
        t_xtea_rsp         rsp;
        v0 = req.first_word;
        v1 = req.second_word;
        if (req.op == OP_ENC) begin
            sum = '0;
            for (int r = 0; r < rounds_shadow; r++) begin
                v0  = v0 + (feistel_mix(v1) ^ (sum + key_shadow[sum[1:0]]));
                sum = sum + XTEA_DELTA;
                v1  = v1 + (feistel_mix(v0) ^ (sum + key_shadow[sum[12:11]]));
            end
        end else begin
            sum = XTEA_DELTA * {{(WORD_W-ROUNDS_W){1'b0}}, rounds_shadow};
            for (int r = 0; r < rounds_shadow; r++) begin
                v1  = v1 - (feistel_mix(v0) ^ (sum + key_shadow[sum[12:11]]));
                sum = sum - XTEA_DELTA;
                v0  = v0 - (feistel_mix(v1) ^ (sum + key_shadow[sum[1:0]]));
            end
        end
        rsp.first_result  = v0;
        rsp.second_result = v1;
        return rsp;
    endfunction

    // one request; start is left high so the next request can follow at once
    task automatic send_block(input logic op, input logic [WORD_W-1:0] a,
                              input logic [WORD_W-1:0] b);
        t_xtea_req   req;
        int unsigned roll;
        int unsigned gap;
        req.op          = op;
        req.first_word  = a;
        req.second_word = b;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            gap = 0;
        end else if (roll < 93) begin
            gap = $urandom_range(1, 4);
        end else begin
            gap = $urandom_range(10, 80);
        end
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= req;
        do @(negedge i_clk); while (o_busy);
        @(posedge i_clk);
        progress_ticks++;
        pending_blocks.insert(pending_blocks.size(), xtea_transform(req));
    endtask

    task automatic send_random_block();
        send_block($urandom_range(0, 1) ? OP_DEC : OP_ENC, $urandom, $urandom);
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        while (pending_blocks.size() > 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        progress_ticks++;
        case (idx) inside
            CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: begin
                key_shadow[idx[1:0]] = data;
            end
            CFG_ROUNDS: begin
                rounds_shadow = data[ROUNDS_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // block must be drained before this is called
    task automatic load_settings(input t_key key, input logic [WORD_W-1:0] rounds);
        write_reg(CFG_KEY0, key[0]);
        write_reg(CFG_KEY1, key[1]);
        write_reg(CFG_KEY2, key[2]);
        write_reg(CFG_KEY3, key[3]);
        write_reg(CFG_ROUNDS, rounds);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_default_key();
        send_block(OP_ENC, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_DEC, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(OP_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(OP_ENC, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(OP_DEC, 32'hAAAA_AAAA, 32'h5555_5555);
        drain_results();
    endtask

    task automatic test_round_extremes();
        // zero rounds passes the block through
        load_settings({32'h0BAD_F00D, 32'h1357_9BDF, 32'h2468_ACE0, 32'hDEAD_BEEF}, 0);
        send_block(OP_ENC, 32'h8000_0001, 32'h7FFF_FFFE);
        send_block(OP_DEC, 32'h5555_AAAA, 32'hAAAA_5555);
        drain_results();
        load_settings({32'h0BAD_F00D, 32'h1357_9BDF, 32'h2468_ACE0, 32'hDEAD_BEEF}, 1);
        send_block(OP_ENC, 32'hFFFF_FFFF, 32'h0000_0000);
        send_block(OP_DEC, 32'h0000_0000, 32'hFFFF_FFFF);
        drain_results();
        load_settings({4{32'hFFFF_FFFF}}, 255);
        send_block(OP_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(OP_DEC, 32'h0000_0000, 32'h0000_0000);
        drain_results();
        load_settings({4{32'h0000_0000}}, 32);
        send_block(OP_ENC, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_unused_index();
        load_settings({$urandom, $urandom, $urandom, $urandom}, 16);
        @(posedge i_clk);
        for (int idx = CFG_ROUNDS + 1; idx < (1 << CFG_IDX_W); idx++) begin
            write_reg(idx[CFG_IDX_W-1:0], $urandom);
        end
        i_cfg_valid <= 1'b0;
        send_block(OP_ENC, $urandom, $urandom);
        send_block(OP_DEC, $urandom, $urandom);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int unsigned sel;
        int unsigned rounds;
        int unsigned count;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            sel = $urandom_range(0, 9);
            if (phase == 0) begin
                sel = 9;
            end
            case (sel) inside
                0:       rounds = $urandom_range(0, 3);
                [1:4]:   rounds = $urandom_range(4, 24);
                [5:7]:   rounds = 32;
                8:       rounds = $urandom_range(33, 64);
                default: rounds = 255;
            endcase
            load_settings({$urandom, $urandom, $urandom, $urandom}, rounds);
            count = (rounds == 255) ? 6 : 110;
            repeat (count) send_random_block();
            drain_results();
        end
    endtask

    always @(negedge i_clk) begin
        t_xtea_rsp want;
        if (i_rst_n && o_done) begin
            progress_ticks++;
            if (pending_blocks.size() == 0) begin
                $error("unexpected result first_result=%h second_result=%h",
                       o_rsp.first_result, o_rsp.second_result);
                mismatch_count++;
            end else begin
                want = pending_blocks.pop_front();
                if (o_rsp.first_result !== want.first_result) begin
                    $error("first_result expected %h actual %h",
                           want.first_result, o_rsp.first_result);
                    mismatch_count++;
                end
                if (o_rsp.second_result !== want.second_result) begin
                    $error("second_result expected %h actual %h",
                           want.second_result, o_rsp.second_result);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (progress_ticks != seen_ticks) begin
            seen_ticks   = progress_ticks;
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_key();
        test_round_extremes();
        test_unused_index();
        test_random_traffic();
        drain_results();
        repeat (2 * rounds_shadow + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_blocks.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
